// File: rtl/eie_pkg.sv
package eie_pkg;

	localparam int OUT_DIM     = 2;
	localparam int IN_DIM      = 2;
	localparam int COUNT_LIMIT = 63;
	localparam int CNT_W       = $clog2(COUNT_LIMIT + 1);

	localparam int DATA_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// residual accumulator, estimate and saturation input widths
	localparam int ACC_W    = 34;
	localparam int EST_W    = 32;
	localparam int SAT_IN_W = 40;
	localparam int W_W      = 17;
	localparam int STEP_W   = 3;

	localparam int Q_FRAC       = 8;
	localparam int ROUND_HALF8  = 1 << (Q_FRAC - 1);
	localparam int ROUND_HALF16 = 1 << 15;
	localparam int WGT_SHIFT    = 16;

	localparam int MAC_STEPS = 4;
	localparam int UPD_STEPS = 2;

	localparam logic [W_W-1:0] ONE_Q16 = W_W'(65536);

	// floor(x / 15) for x below 180 as (x * 137) >> 11
	localparam int DECAY_PERIOD   = 15;
	localparam int DECAY_LEN      = 12;
	localparam int DECAY_RANGE    = DECAY_PERIOD * DECAY_LEN;
	localparam int DECAY_RECIP    = 137;
	localparam int DECAY_RECIP_SH = 11;
	localparam int BOOST_LEN      = 14;

	localparam logic [W_W-1:0] DECAY_TAB [DECAY_LEN] = '{
		17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442,
		17'd162, 17'd60, 17'd22, 17'd8, 17'd3, 17'd1
	};

	localparam logic [W_W-1:0] BOOST_TAB [BOOST_LEN] = '{
		17'd65536, 17'd61309, 17'd50196, 17'd35967, 17'd22554, 17'd12378, 17'd5945,
		17'd2499, 17'd919, 17'd296, 17'd83, 17'd21, 17'd4, 17'd1
	};

	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_EN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_INDEX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STARTUP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd4;

	typedef struct packed {
		logic signed [DATA_W-1:0] meas_0;
		logic signed [DATA_W-1:0] meas_1;
		logic signed [DATA_W-1:0] recipe_0;
		logic signed [DATA_W-1:0] recipe_1;
		logic                     start_history;
	} eie_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] intercept_0;
		logic signed [DATA_W-1:0] intercept_1;
	} eie_out_t;

	typedef struct packed {
		logic [15:0]           smoothing_weight;
		logic                  decay_enable;
		logic [15:0]           run_index;
		logic                  startup_mode;
		logic [CFG_DATA_W-1:0] gain_matrix;
	} eie_cfg_t;

	function automatic logic signed [EST_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
		logic signed [EST_W-1:0] r;
		if (v[SAT_IN_W-1:EST_W-1] == '0 || v[SAT_IN_W-1:EST_W-1] == '1) begin
			r = v[EST_W-1:0];
		end else if (v[SAT_IN_W-1]) begin
			r = {1'b1, {(EST_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(EST_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[SAT_IN_W-1:DATA_W-1] == '0 || v[SAT_IN_W-1:DATA_W-1] == '1) begin
			r = v[DATA_W-1:0];
		end else if (v[SAT_IN_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// File: rtl/eie_mul.sv
module eie_mul import eie_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p
);

	logic signed [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// File: rtl/eie_core.sv
module eie_core import eie_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  eie_cfg_t cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  eie_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output eie_out_t out_data
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_DECAY = 9'b000000010,
		ST_LAM   = 9'b000000100,
		ST_BOOST = 9'b000001000,
		ST_WGT   = 9'b000010000,
		ST_MAC   = 9'b000100000,
		ST_DIFF  = 9'b001000000,
		ST_UPD   = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t                    state_q;
	logic [STEP_W-1:0]         step_q;
	logic [CNT_W-1:0]          items_seen_q;
	logic [CNT_W-1:0]          n_q;
	logic                      first_q;
	logic signed [DATA_W-1:0]  y_q    [2];
	logic signed [DATA_W-1:0]  u_q    [2];
	logic [W_W-1:0]            f_q;
	logic [W_W-1:0]            boost_q;
	logic [15:0]               lam_q;
	logic [W_W-1:0]            w_q;
	logic signed [ACC_W-1:0]   d_q    [2];
	logic signed [ACC_W-1:0]   diff_q [2];
	logic signed [EST_W-1:0]   e_q    [2];
	logic                      out_valid_q;
	eie_out_t                  out_q;

	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [MUL_P_W-1:0]  mul_p;
	logic signed [MUL_P_W-1:0]  rnd_p;
	logic [STEP_W-1:0]          prev;
	logic signed [ACC_W-1:0]    mac_base;
	logic signed [ACC_W-1:0]    mac_val;
	logic signed [SAT_IN_W-1:0] upd_sum;
	logic [W_W:0]               wgt_sum;
	logic [CNT_W-1:0]           n_next;
	logic                       first_next;
	logic [15:0]                ri_scaled;
	logic signed [SAT_IN_W-1:0] r0;
	logic signed [SAT_IN_W-1:0] r1;
	logic                       in_xfer;
	logic                       out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	eie_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DECAY: begin
				mul_a = MUL_A_W'(cfg.smoothing_weight);
				mul_b = MUL_B_W'(f_q);
			end
			ST_BOOST: begin
				mul_a = MUL_A_W'(lam_q);
				mul_b = MUL_B_W'(boost_q);
			end
			ST_MAC: begin
				// entry 2j+k of the gain matrix times input k
				mul_a = MUL_A_W'(u_q[step_q[0]]);
				mul_b = MUL_B_W'($signed(cfg.gain_matrix[{step_q[1:0], 4'b0000} +: DATA_W]));
			end
			ST_UPD: begin
				mul_a = MUL_A_W'(diff_q[step_q[0]]);
				mul_b = MUL_B_W'(w_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		rnd_p    = (mul_p + MUL_P_W'(ROUND_HALF16)) >>> WGT_SHIFT;
		prev     = step_q - STEP_W'(1);
		mac_base = prev[0] ? d_q[prev[1]] : (ACC_W'(y_q[prev[1]]) <<< Q_FRAC);
		mac_val  = mac_base - ACC_W'(mul_p);
		upd_sum  = SAT_IN_W'(e_q[prev[0]]) + SAT_IN_W'(rnd_p);
		wgt_sum  = {2'b00, lam_q} + (W_W + 1)'(rnd_p[W_W-1:0]);
		first_next = in_data.start_history || (items_seen_q == '0);
		if (first_next) begin
			n_next = CNT_W'(1);
		end else if (items_seen_q >= CNT_W'(COUNT_LIMIT)) begin
			n_next = CNT_W'(COUNT_LIMIT);
		end else begin
			n_next = items_seen_q + CNT_W'(1);
		end
		ri_scaled = 16'(cfg.run_index[7:0]) * 16'(DECAY_RECIP);
		r0 = (SAT_IN_W'(e_q[0]) + SAT_IN_W'(ROUND_HALF8)) >>> Q_FRAC;
		r1 = (SAT_IN_W'(e_q[1]) + SAT_IN_W'(ROUND_HALF8)) >>> Q_FRAC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			items_seen_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_DECAY;
					end
				end
				ST_DECAY: state_q <= ST_LAM;
				ST_LAM:   state_q <= ST_BOOST;
				ST_BOOST: state_q <= ST_WGT;
				ST_WGT: begin
					state_q <= ST_MAC;
					step_q  <= '0;
				end
				ST_MAC: begin
					if (step_q == STEP_W'(MAC_STEPS)) begin
						state_q <= ST_DIFF;
						step_q  <= '0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_DIFF: state_q <= ST_UPD;
				ST_UPD: begin
					if (step_q == STEP_W'(UPD_STEPS)) begin
						state_q <= ST_OUT;
						step_q  <= '0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q      <= ST_IDLE;
						out_valid_q  <= 1'b1;
						items_seen_q <= n_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			y_q[0]  <= (OUT_DIM > 0) ? in_data.meas_0 : '0;
			y_q[1]  <= (OUT_DIM > 1) ? in_data.meas_1 : '0;
			u_q[0]  <= (IN_DIM > 0) ? in_data.recipe_0 : '0;
			u_q[1]  <= (IN_DIM > 1) ? in_data.recipe_1 : '0;
			first_q <= first_next;
			n_q     <= n_next;
			if (!cfg.decay_enable) begin
				f_q <= ONE_Q16;
			end else if (cfg.run_index < 16'(DECAY_RANGE)) begin
				f_q <= DECAY_TAB[ri_scaled[DECAY_RECIP_SH +: 4]];
			end else begin
				f_q <= '0;
			end
			if (cfg.startup_mode && n_next < CNT_W'(BOOST_LEN)) begin
				boost_q <= BOOST_TAB[n_next[3:0]];
			end else begin
				boost_q <= '0;
			end
		end
		if (state_q == ST_LAM) begin
			lam_q <= rnd_p[15:0];
		end
		if (state_q == ST_WGT) begin
			w_q <= (wgt_sum > (W_W + 1)'(ONE_Q16)) ? ONE_Q16 : wgt_sum[W_W-1:0];
		end
		// accumulate the product issued one step earlier
		if (state_q == ST_MAC && step_q != '0) begin
			if (prev[0]) begin
				d_q[prev[1]] <= ACC_W'(sat32(SAT_IN_W'(mac_val)));
			end else begin
				d_q[prev[1]] <= mac_val;
			end
		end
		if (state_q == ST_DIFF) begin
			diff_q[0] <= d_q[0] - ACC_W'(e_q[0]);
			diff_q[1] <= d_q[1] - ACC_W'(e_q[1]);
		end
		if (state_q == ST_UPD && step_q != '0) begin
			if (int'(prev[0]) >= OUT_DIM) begin
				e_q[prev[0]] <= '0;
			end else if (first_q) begin
				e_q[prev[0]] <= d_q[prev[0]][EST_W-1:0];
			end else begin
				e_q[prev[0]] <= sat32(upd_sum);
			end
		end
		if (out_load) begin
			out_q.intercept_0 <= sat16(r0);
			out_q.intercept_1 <= sat16(r1);
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_DECAY && !in_ready))
		else $error("accepted item did not start the weight sequence");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		items_seen_q <= CNT_W'(COUNT_LIMIT))
		else $error("run count beyond its limit");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output step");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECAY) |-> (n_q != '0 && (!first_q || n_q == CNT_W'(1))))
		else $error("bad run number for this item");

	a_weight_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> (w_q <= ONE_Q16))
		else $error("weight above one");

endmodule

// File: rtl/ewma_intercept_estimator.sv
// channel  | direction | handshake               | payload
// in       | input     | in_valid / in_ready     | in_data (eie_in_t)
// out      | output    | out_valid / out_ready   | out_data (eie_out_t)
// cfg      | input     | cfg_wen (no wait)       | cfg_index, cfg_data
//
// an item passes through the decay, lambda, boost, weight, residual, difference,
// update and output steps from its input transfer to a valid result; the next item
// is taken only once the sequencer is back in idle, since the shared multiplier does
// two weight products, four residual products and two update products in sequence
// reset clears the config registers to their defaults, the run count and the
// result flag; a stalled result holds the sequencer in its output step
module ewma_intercept_estimator import eie_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  eie_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output eie_out_t              out_data,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	eie_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smoothing_weight <= 16'd13107;
			cfg_q.decay_enable     <= 1'b0;
			cfg_q.run_index        <= '0;
			cfg_q.startup_mode     <= 1'b0;
			cfg_q.gain_matrix      <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_SMOOTHING: cfg_q.smoothing_weight <= cfg_data[15:0];
				REG_DECAY_EN:  cfg_q.decay_enable     <= cfg_data[0];
				REG_RUN_INDEX: cfg_q.run_index        <= cfg_data[15:0];
				REG_STARTUP:   cfg_q.startup_mode     <= cfg_data[0];
				REG_GAIN:      cfg_q.gain_matrix      <= cfg_data;
				default: ;
			endcase
		end
	end

	eie_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import eie_pkg::*;

	localparam int     DECAY_STEP = 15;
	localparam longint EST_MAX    = (longint'(1) <<< 31) - 1;
	localparam longint EST_MIN    = -(longint'(1) <<< 31);
	localparam longint ONE_WT     = 65536;

	// exp(-k) and exp(-n*n/15) in unsigned Q1.16
	localparam longint DECAY_FACTOR [12] = '{
		65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1
	};
	localparam longint BOOST_FACTOR [14] = '{
		65536, 61309, 50196, 35967, 22554, 12378, 5945, 2499, 919, 296, 83, 21, 4, 1
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	eie_in_t               in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	eie_out_t              out_data;
	logic                  cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// settings and state as the block should hold them
	logic [15:0] smooth_wt = 16'd13107;
	bit          decay_on  = 1'b0;
	logic [15:0] run_idx   = '0;
	bit          boost_on  = 1'b0;
	logic [63:0] gain      = '0;
	longint      est [2]   = '{0, 0};
	int          runs_seen = 0;

	eie_in_t  run_q [$];
	eie_out_t intercept_q [$];
	int       mismatches  = 0;
	int       burst_left  = 0;
	int       gap_left    = 0;
	int       stall_cyc   = 0;

	ewma_intercept_estimator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (mismatches < 50) begin
			$display("%0t mismatch: %s", $time, msg);
		end
		mismatches++;
	endtask

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic predict_intercepts(input eie_in_t it);
		longint   y [2];
		longint   u [2];
		longint   lam, d, e, g;
		int       n, k;
		bit       first;
		longint   o [2];
		eie_out_t res;
		y[0] = it.meas_0;
		y[1] = it.meas_1;
		u[0] = it.recipe_0;
		u[1] = it.recipe_1;
		first = it.start_history || runs_seen == 0;
		n = first ? 1 : ((runs_seen + 1 > COUNT_LIMIT) ? COUNT_LIMIT : runs_seen + 1);
		lam = smooth_wt;
		if (decay_on) begin
			k = run_idx / DECAY_STEP;
			lam = (k < 12) ? ((lam * DECAY_FACTOR[k] + 32768) >>> 16) : 0;
		end
		if (boost_on && n < 14) begin
			lam = lam + ((lam * BOOST_FACTOR[n] + 32768) >>> 16);
		end
		if (lam > ONE_WT) begin
			lam = ONE_WT;
		end
		for (int j = 0; j < 2; j++) begin
			d = y[j] * 256;
			for (int c = 0; c < 2; c++) begin
				g = $signed(gain[16 * (2 * j + c) +: 16]);
				d -= g * u[c];
			end
			d = clip(d, EST_MIN, EST_MAX);
			if (first) begin
				e = d;
			end else begin
				e = est[j] + ((lam * (d - est[j]) + 32768) >>> 16);
				e = clip(e, EST_MIN, EST_MAX);
			end
			est[j] = e;
			o[j] = clip((e + 128) >>> 8, -32768, 32767);
		end
		runs_seen = n;
		res.intercept_0 = 16'(o[0]);
		res.intercept_1 = 16'(o[1]);
		intercept_q.push_back(res);
	endtask

	// sender: bursts of transfers with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_intercepts(in_data);
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (run_q.size() != 0) begin
					in_data <= run_q.pop_front();
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: steps through four stall patterns chosen by bits 9:8 of a running counter
	always @(posedge clk or negedge arst_n) begin : result_check
		eie_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (intercept_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", out_data));
				end else begin
					want = intercept_q.pop_front();
					if (out_data.intercept_0 !== want.intercept_0) begin
						report_mismatch($sformatf("intercept_0 got %h want %h",
							out_data.intercept_0, want.intercept_0));
					end
					if (out_data.intercept_1 !== want.intercept_1) begin
						report_mismatch($sformatf("intercept_1 got %h want %h",
							out_data.intercept_1, want.intercept_1));
					end
				end
			end
			stall_cyc++;
			case (stall_cyc[9:8])
				2'd0: begin
					out_ready <= 1'b1;
				end
				2'd1: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				2'd2: begin
					out_ready <= stall_cyc[2:0] != 3'd0;
				end
				default: begin
					out_ready <= stall_cyc[4:0] < 5'd4;
				end
			endcase
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SMOOTHING: smooth_wt = val[15:0];
			REG_DECAY_EN:  decay_on = val[0];
			REG_RUN_INDEX: run_idx = val[15:0];
			REG_STARTUP:   boost_on = val[0];
			REG_GAIN:      gain = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic push_run(input logic [15:0] m0, m1, r0, r1, input logic st);
		eie_in_t it;
		it.meas_0 = m0;
		it.meas_1 = m1;
		it.recipe_0 = r0;
		it.recipe_1 = r1;
		it.start_history = st;
		run_q.push_back(it);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (run_q.size() != 0 || in_valid || intercept_q.size() != 0);
	endtask

	function automatic logic [15:0] rand_q78();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 511)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_gain_entry(input bit wide);
		return wide ? 16'($urandom) : 16'($urandom_range(0, 1023)) - 16'd512;
	endfunction

	task automatic randomize_settings();
		logic [15:0] wt, ri;
		bit          wide;
		case ($urandom_range(0, 5))
			0: wt = 16'd0;
			1: wt = 16'hffff;
			default: wt = 16'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0: ri = 16'd0;
			1: ri = 16'd14;
			2: ri = 16'd15;
			3: ri = 16'd179;
			4: ri = 16'd180;
			5: ri = 16'hffff;
			default: ri = 16'($urandom_range(0, 200));
		endcase
		wide = $urandom_range(0, 2) == 0;
		cfg_write(REG_SMOOTHING, 64'(wt));
		cfg_write(REG_DECAY_EN, 64'($urandom_range(0, 1)));
		cfg_write(REG_RUN_INDEX, 64'(ri));
		cfg_write(REG_STARTUP, 64'($urandom_range(0, 1)));
		cfg_write(REG_GAIN, {rand_gain_entry(wide), rand_gain_entry(wide),
			rand_gain_entry(wide), rand_gain_entry(wide)});
	endtask

	initial begin : stimulus
		int restart_rate;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// defaults, zero gain; the first run after reset counts as a new history
		push_run(16'd100, -16'sd200, 16'd5, 16'd6, 1'b0);
		push_run(16'h7fff, 16'h8000, 16'd0, 16'd0, 1'b0);
		push_run(16'h8000, 16'h7fff, 16'd7, -16'sd7, 1'b0);
		push_run(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
		wait_drained();

		// most negative gains drive the residual into saturation, full weight boost
		cfg_write(REG_GAIN, {4{16'h8000}});
		cfg_write(REG_SMOOTHING, 64'hffff);
		cfg_write(REG_STARTUP, 64'd1);
		push_run(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
		push_run(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
		push_run(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0);
		push_run(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
		wait_drained();

		// last decay step that still has a nonzero factor
		cfg_write(REG_GAIN, {4{16'h7fff}});
		cfg_write(REG_DECAY_EN, 64'd1);
		cfg_write(REG_RUN_INDEX, 64'd179);
		cfg_write(REG_SMOOTHING, 64'd40000);
		cfg_write(REG_STARTUP, 64'd0);
		push_run(16'h1234, -16'sd4000, 16'd3, -16'sd9, 1'b1);
		push_run(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 1'b0);
		push_run(-16'sd1, 16'd1, 16'h7fff, 16'h7fff, 1'b0);
		wait_drained();

		// decay factor drops to zero, estimate frozen
		cfg_write(REG_RUN_INDEX, 64'd180);
		push_run(16'd500, 16'd600, 16'd1, 16'd2, 1'b0);
		push_run(16'h8000, 16'h7fff, 16'd0, 16'd0, 1'b0);
		wait_drained();

		cfg_write(REG_RUN_INDEX, 64'hffff);
		cfg_write(REG_STARTUP, 64'd1);
		for (int i = REG_GAIN + 1; i < 2 ** CFG_IDX_W; i++) begin
			cfg_write(CFG_IDX_W'(i), {$urandom, $urandom});
		end
		push_run(16'd256, -16'sd256, 16'd256, 16'd256, 1'b1);
		push_run(16'd512, 16'd512, 16'd0, 16'd0, 1'b0);
		push_run(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0);

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			randomize_settings();
			// odd phases never restart so the run count reaches its limit
			restart_rate = (ph % 2 == 0) ? 6 : 0;
			for (int i = 0; i < 75; i++) begin
				push_run(rand_q78(), rand_q78(), rand_q78(), rand_q78(),
					restart_rate != 0 && $urandom_range(0, restart_rate - 1) == 0);
			end
		end

		wait_drained();
		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#1000000;
		$display("tb: FAIL");
		$finish;
	end

endmodule

// File: files.f
rtl/eie_pkg.sv
rtl/eie_mul.sv
rtl/eie_core.sv
rtl/ewma_intercept_estimator.sv
sim/tb.sv
